// File: rtl/ppcpd_pkg.sv
// shared types and constants for the instruction predecoder
package ppcpd_pkg;

   typedef enum logic [2:0] {
      CLS_INT = 3'd0,
      CLS_LS  = 3'd1,
      CLS_FLT = 3'd2,
      CLS_PS  = 3'd3,
      CLS_BR  = 3'd4,
      CLS_SYS = 3'd5,
      CLS_UNK = 3'd6
   } class_type;

   localparam logic [5:0] OP_PS    = 6'd4;
   localparam logic [5:0] OP_BC    = 6'd16;
   localparam logic [5:0] OP_SC    = 6'd17;
   localparam logic [5:0] OP_B     = 6'd18;
   localparam logic [5:0] OP_T19   = 6'd19;
   localparam logic [5:0] OP_T31   = 6'd31;
   localparam logic [5:0] OP_T59   = 6'd59;
   localparam logic [5:0] OP_T63   = 6'd63;

   localparam logic [9:0] XO_BCLR  = 10'd16;
   localparam logic [9:0] XO_BCCTR = 10'd528;
   localparam logic [9:0] XO_RFI   = 10'd50;

   localparam logic [4:0] BO_ALWAYS = 5'h14;

   // 5-bit sub-opcode sets
   localparam logic [31:0] MASK_T59 = 32'hF374_0000;
   localparam logic [31:0] MASK_T63 = 32'hF6F4_0000;
   localparam logic [31:0] MASK_T4  = 32'hF7B4_FC00;

   localparam logic [31:0] NO_TARGET = 32'hFFFF_FFFF;

   typedef struct packed {
      class_type   instr_class;
      logic        flow_change;
      logic        cond_flow;
      logic        link_flag;
      logic        abs_flag;
      logic        target_valid;
      logic [31:0] jump_target;
      logic        block_end;
   } result_type;

endpackage

// File: rtl/ppcpd_decode.sv
// combinational opcode classification, branch flags and target computation
module ppcpd_decode (
   input  logic [31:0]            instr_word,
   input  logic [31:0]            instr_address,
   output ppcpd_pkg::result_type  result
);
   import ppcpd_pkg::*;

   function automatic class_type class_t31(input logic [9:0] x10);
      class_type c;
      c = CLS_UNK;
      unique case (x10)
         10'd0, 10'd4, 10'd11, 10'd19, 10'd24, 10'd26, 10'd28, 10'd32,
         10'd60, 10'd75, 10'd124, 10'd144, 10'd284, 10'd316, 10'd412,
         10'd444, 10'd476, 10'd512, 10'd536, 10'd792, 10'd824, 10'd922,
         10'd954:
            c = CLS_INT;
         10'd20, 10'd23, 10'd54, 10'd55, 10'd86, 10'd87, 10'd119, 10'd150,
         10'd151, 10'd183, 10'd215, 10'd247, 10'd279, 10'd311, 10'd343,
         10'd375, 10'd407, 10'd439, 10'd470, 10'd533, 10'd534, 10'd597,
         10'd661, 10'd662, 10'd725, 10'd790, 10'd918, 10'd982, 10'd1014:
            c = CLS_LS;
         10'd535, 10'd567, 10'd599, 10'd631, 10'd663, 10'd695, 10'd727,
         10'd759, 10'd983:
            c = CLS_FLT;
         10'd83, 10'd146, 10'd306, 10'd310, 10'd339, 10'd371, 10'd438,
         10'd467, 10'd566, 10'd595, 10'd598, 10'd659, 10'd854:
            c = CLS_SYS;
         default:
            c = CLS_UNK;
      endcase
      // xo-form arithmetic ignores the oe bit
      unique case (x10[8:0])
         9'd8, 9'd10, 9'd40, 9'd104, 9'd136, 9'd138, 9'd200, 9'd202,
         9'd234, 9'd235, 9'd266, 9'd459, 9'd491:
            c = CLS_INT;
         default: ;
      endcase
      return c;
   endfunction

   function automatic class_type class_t63(input logic [9:0] x10, input logic [4:0] x5);
      class_type c;
      unique case (x10)
         10'd0, 10'd12, 10'd14, 10'd15, 10'd32, 10'd38, 10'd40, 10'd64,
         10'd70, 10'd72, 10'd134, 10'd136, 10'd264, 10'd583, 10'd711:
            c = CLS_FLT;
         default:
            c = MASK_T63[x5] ? CLS_FLT : CLS_UNK;
      endcase
      return c;
   endfunction

   function automatic class_type class_t4(input logic [9:0] x10, input logic [4:0] x5);
      class_type c;
      unique case (x10)
         10'd0, 10'd32, 10'd40, 10'd64, 10'd72, 10'd96, 10'd136, 10'd264,
         10'd528, 10'd560, 10'd592, 10'd624:
            c = CLS_PS;
         default:
            c = MASK_T4[x5] ? CLS_PS : CLS_UNK;
      endcase
      return c;
   endfunction

   function automatic class_type class_t19(input logic [9:0] x10);
      class_type c;
      unique case (x10)
         10'd50, 10'd150:
            c = CLS_SYS;
         10'd0, 10'd33, 10'd129, 10'd193, 10'd225, 10'd257, 10'd289,
         10'd417, 10'd449:
            c = CLS_INT;
         default:
            c = CLS_UNK;
      endcase
      return c;
   endfunction

   logic [5:0]  op;
   logic [9:0]  x10;
   logic [4:0]  x5;
   logic [4:0]  bo;
   logic [31:0] disp_b;
   logic [31:0] disp_bc;
   logic [31:0] disp;
   logic [31:0] target;

   assign op      = instr_word[31:26];
   assign x10     = instr_word[10:1];
   assign x5      = instr_word[5:1];
   assign bo      = instr_word[25:21];
   assign disp_b  = {{6{instr_word[25]}}, instr_word[25:2], 2'b00};
   assign disp_bc = {{16{instr_word[15]}}, instr_word[15:2], 2'b00};
   assign disp    = (op == OP_B) ? disp_b : disp_bc;
   assign target  = instr_word[1] ? disp : instr_address + disp;

   always_comb begin
      result = '{instr_class: CLS_UNK, jump_target: NO_TARGET, default: 1'b0};
      unique case (op)
         OP_B: begin
            result.instr_class  = CLS_BR;
            result.flow_change  = 1'b1;
            result.link_flag    = instr_word[0];
            result.abs_flag     = instr_word[1];
            result.target_valid = 1'b1;
            result.jump_target  = target;
            result.block_end    = 1'b1;
         end
         OP_BC: begin
            result.instr_class  = CLS_BR;
            result.flow_change  = 1'b1;
            result.cond_flow    = 1'b1;
            result.link_flag    = instr_word[0];
            result.abs_flag     = instr_word[1];
            result.target_valid = 1'b1;
            result.jump_target  = target;
         end
         OP_T19: begin
            if (x10 == XO_BCLR || x10 == XO_BCCTR) begin
               result.instr_class = CLS_BR;
               result.flow_change = 1'b1;
               result.cond_flow   = 1'b1;
               result.link_flag   = instr_word[0];
               result.block_end   = (bo & BO_ALWAYS) == BO_ALWAYS;
            end else begin
               result.instr_class = class_t19(x10);
               result.flow_change = x10 == XO_RFI;
               result.block_end   = x10 == XO_RFI;
            end
         end
         OP_SC: begin
            result.instr_class = CLS_SYS;
            result.flow_change = 1'b1;
            result.block_end   = 1'b1;
         end
         6'd3, 6'd7, 6'd8, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
         6'd20, 6'd21, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29:
            result.instr_class = CLS_INT;
         OP_T31:
            result.instr_class = class_t31(x10);
         OP_T59:
            result.instr_class = MASK_T59[x5] ? CLS_FLT : CLS_UNK;
         OP_T63:
            result.instr_class = class_t63(x10, x5);
         OP_PS:
            result.instr_class = class_t4(x10, x5);
         6'd56, 6'd57, 6'd60, 6'd61:
            result.instr_class = CLS_PS;
         default: begin
            if (op[5:4] == 2'b10) begin
               result.instr_class = CLS_LS;
            end else if (op[5:3] == 3'b110) begin
               result.instr_class = CLS_FLT;
            end else begin
               result.instr_class = CLS_UNK;
            end
         end
      endcase
   end

endmodule

// File: rtl/powerpc_instruction_predecoder_core.sv
// top level of the instruction predecoder: input register, decode, result register
//
// usage
//   req_* carries one instruction word and its address per transaction.
//   rsp_* returns exactly one predecode result per request, in order.
//   a transaction moves on a rising edge with tvalid and tready both high.
// pipeline and throughput
//   an accepted word sits in the input register; decode feeds the result
//   register, which drives rsp_tvalid and rsp_tdata until the result is taken.
//   one transaction per cycle sustained while rsp_tready stays high; the decode
//   is a single pass of opcode table lookup plus one 32-bit target add.
// stalls
//   when rsp_tready is low the result register holds its transaction and the
//   input register keeps accepting until it too is full; req_tready drops
//   only when both registers hold transactions that cannot move.
// reset
//   synchronous, active high; clears both valid flags, no transaction
//   is in flight afterward. no configuration; data registers are not reset.
module powerpc_instruction_predecoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // instr_word[31:0], instr_address[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // instr_class[2:0], flow_change[3],
                                   // cond_flow[4], link_flag[5],
                                   // abs_flag[6], target_valid[7],
                                   // jump_target[39:8], block_end[40], zero[47:41]
);
   import ppcpd_pkg::*;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [31:0] word_ff;
   logic [31:0] addr_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   result_type  result_ff;
   result_type  result_in;
   logic        advance;
   logic        take;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   ppcpd_decode u_decode (
      .instr_word    (word_ff),
      .instr_address (addr_ff),
      .result        (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= req_tdata[31:0];
         addr_ff <= req_tdata[63:32];
      end
      if (advance && in_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0,
                        result_ff.block_end,
                        result_ff.jump_target,
                        result_ff.target_valid,
                        result_ff.abs_flag,
                        result_ff.link_flag,
                        result_ff.cond_flow,
                        result_ff.flow_change,
                        result_ff.instr_class};

endmodule
